// ----- rtl/mhdd_pkg.sv -----
// Shared constants, codes and types of the motion hysteresis dwell detector.
`timescale 1ns / 1ps

package mhdd_pkg;

    localparam int TIME_BITS  = 40;
    localparam int MAX_PIXELS = 4194304;

    localparam int CMD_W      = 2;
    localparam int DUR_W      = 32;
    localparam int CNT_W      = 23;
    localparam int RATIO_W    = 17;
    localparam int CONF_W     = 20;
    localparam int FRAC_BITS  = 16;
    localparam int SUP_W      = TIME_BITS + 1;
    localparam int LHS_W      = CNT_W + FRAC_BITS;
    localparam int PROD_W     = RATIO_W + CNT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int IN_FIELD_W  = TIME_BITS + DUR_W + 1 + 1 + CNT_W + CNT_W;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 4 + TIME_BITS + TIME_BITS;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_FRAME    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUPPRESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOVING_CONFIRM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_CONFIRM  = 2'd3;

    localparam logic [RATIO_W-1:0] START_LEVEL_RESET = 17'd1311;
    localparam logic [RATIO_W-1:0] STOP_LEVEL_RESET  = 17'd655;

    typedef struct packed {
        logic [RATIO_W-1:0] start_level;
        logic [RATIO_W-1:0] stop_level;
        logic [CONF_W-1:0]  moving_confirm_time;
        logic [CONF_W-1:0]  still_confirm_time;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [TIME_BITS-1:0] now_time;
        logic [SUP_W-1:0]     suppress_end;
        logic                 has_frame;
        logic                 size_changed;
        logic                 valid_zero;
        logic [LHS_W-1:0]     lhs;
        logic [PROD_W-1:0]    start_prod;
        logic [PROD_W-1:0]    stop_prod;
    } stage_item_t;

    typedef struct packed {
        logic moving_flag;
        logic motion_pending;
        logic still_pending;
    } status_t;

endpackage

// ----- rtl/mhdd_cfg_regs.sv -----
// Configuration registers with their reset values.
`timescale 1ns / 1ps

module mhdd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mhdd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [mhdd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output mhdd_pkg::cfg_t                 cfg
);
    import mhdd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_START_LEVEL:    cfg_next.start_level = cfg_wdata[RATIO_W-1:0];
                REG_STOP_LEVEL:     cfg_next.stop_level = cfg_wdata[RATIO_W-1:0];
                REG_MOVING_CONFIRM: cfg_next.moving_confirm_time = cfg_wdata[CONF_W-1:0];
                REG_STILL_CONFIRM:  cfg_next.still_confirm_time = cfg_wdata[CONF_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level         <= START_LEVEL_RESET;
            cfg_reg.stop_level          <= STOP_LEVEL_RESET;
            cfg_reg.moving_confirm_time <= '0;
            cfg_reg.still_confirm_time  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/mhdd_ratio_stage.sv -----
// Input stage: count saturation, threshold products and suppress window end.
`timescale 1ns / 1ps

module mhdd_ratio_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mhdd_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mhdd_pkg::IN_DATA_W-1:0] in_data,
    input  logic [mhdd_pkg::CMD_W-1:0]     in_cmd,
    input  logic                           advance,
    output logic                           item_valid,
    output mhdd_pkg::stage_item_t          item
);
    import mhdd_pkg::*;

    localparam int NOW_LO  = 0;
    localparam int DUR_LO  = NOW_LO + TIME_BITS;
    localparam int HF_POS  = DUR_LO + DUR_W;
    localparam int SC_POS  = HF_POS + 1;
    localparam int CHG_LO  = SC_POS + 1;
    localparam int VAL_LO  = CHG_LO + CNT_W;

    logic                 valid_reg;
    logic                 valid_next;
    stage_item_t          item_reg;
    stage_item_t          item_next;

    logic [TIME_BITS-1:0] now_time;
    logic [DUR_W-1:0]     duration;
    logic [CNT_W-1:0]     changed_raw;
    logic [CNT_W-1:0]     valid_raw;
    logic [CNT_W-1:0]     changed_sat;
    logic [CNT_W-1:0]     valid_sat;

    assign now_time    = in_data[NOW_LO +: TIME_BITS];
    assign duration    = in_data[DUR_LO +: DUR_W];
    assign changed_raw = in_data[CHG_LO +: CNT_W];
    assign valid_raw   = in_data[VAL_LO +: CNT_W];

    assign changed_sat = (changed_raw > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : changed_raw;
    assign valid_sat   = (valid_raw > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : valid_raw;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        item_next.cmd          = in_cmd;
        item_next.now_time     = now_time;
        item_next.suppress_end = SUP_W'(now_time) + SUP_W'(duration);
        item_next.has_frame    = in_data[HF_POS];
        item_next.size_changed = in_data[SC_POS];
        item_next.valid_zero   = (valid_sat == '0);
        item_next.lhs          = {changed_sat, {FRAC_BITS{1'b0}}};
        item_next.start_prod   = PROD_W'(cfg.start_level) * PROD_W'(valid_sat);
        item_next.stop_prod    = PROD_W'(cfg.stop_level) * PROD_W'(valid_sat);
        valid_next             = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/mhdd_decide.sv -----
// Decision stage: hysteresis state, dwell timers and the result register.
`timescale 1ns / 1ps

module mhdd_decide (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mhdd_pkg::cfg_t                  cfg,
    input  logic                            item_valid,
    input  mhdd_pkg::stage_item_t           item,
    output logic                            advance,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mhdd_pkg::OUT_DATA_W-1:0] out_data,
    output mhdd_pkg::status_t               status
);
    import mhdd_pkg::*;

    logic                  moving_reg;
    logic                  moving_next;
    logic                  have_prev_reg;
    logic                  have_prev_next;
    logic [TIME_BITS-1:0]  motion_start_reg;
    logic [TIME_BITS-1:0]  motion_start_next;
    logic [TIME_BITS-1:0]  still_start_reg;
    logic [TIME_BITS-1:0]  still_start_next;
    logic [SUP_W-1:0]      suppress_until_reg;
    logic [SUP_W-1:0]      suppress_until_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                  step;
    logic                  above;
    logic                  below;
    logic [TIME_BITS-1:0]  now;
    logic [TIME_BITS-1:0]  m_start;
    logic [TIME_BITS-1:0]  s_start;
    logic [TIME_BITS-1:0]  m_elapsed;
    logic [TIME_BITS-1:0]  s_elapsed;
    logic                  m_done;
    logic                  s_done;
    logic                  res_init;
    logic                  res_supp;
    logic                  res_trans;
    logic [TIME_BITS-1:0]  res_mov_el;
    logic [TIME_BITS-1:0]  res_still_el;

    assign advance = !out_valid_reg || out_ready;
    assign step    = item_valid && advance;
    assign now     = item.now_time;

    assign above = item.valid_zero ? (cfg.start_level == '0)
                                   : (PROD_W'(item.lhs) >= item.start_prod);
    assign below = item.valid_zero ? 1'b1 : (PROD_W'(item.lhs) <= item.stop_prod);

    // A start of zero marks no running candidate, so a new one begins now.
    assign m_start   = (motion_start_reg == '0) ? now : motion_start_reg;
    assign s_start   = (still_start_reg == '0) ? now : still_start_reg;
    assign m_elapsed = (now >= m_start) ? (now - m_start) : '0;
    assign s_elapsed = (now >= s_start) ? (now - s_start) : '0;
    assign m_done    = (cfg.moving_confirm_time == '0) ||
                       (m_elapsed >= TIME_BITS'(cfg.moving_confirm_time));
    assign s_done    = (cfg.still_confirm_time == '0) ||
                       (s_elapsed >= TIME_BITS'(cfg.still_confirm_time));

    always_comb
    begin
        moving_next         = moving_reg;
        have_prev_next      = have_prev_reg;
        motion_start_next   = motion_start_reg;
        still_start_next    = still_start_reg;
        suppress_until_next = suppress_until_reg;
        res_init            = 1'b0;
        res_supp            = 1'b0;
        res_trans           = 1'b0;
        res_mov_el          = '0;
        res_still_el        = '0;
        case (item.cmd)
            CMD_SUPPRESS:
            begin
                have_prev_next      = 1'b0;
                motion_start_next   = '0;
                still_start_next    = '0;
                suppress_until_next = item.suppress_end;
            end
            CMD_CLEAR:
            begin
                moving_next         = 1'b0;
                have_prev_next      = 1'b0;
                motion_start_next   = '0;
                still_start_next    = '0;
                suppress_until_next = '0;
            end
            CMD_FRAME:
            begin
                if (item.has_frame)
                begin
                    res_init = 1'b1;
                    if (!have_prev_reg || item.size_changed)
                    begin
                        have_prev_next = 1'b1;
                    end
                    else if (SUP_W'(now) < suppress_until_reg)
                    begin
                        motion_start_next = '0;
                        still_start_next  = '0;
                        res_supp          = 1'b1;
                    end
                    else if (!moving_reg)
                    begin
                        still_start_next = '0;
                        if (above && m_done)
                        begin
                            moving_next       = 1'b1;
                            motion_start_next = '0;
                            res_trans         = 1'b1;
                        end
                        else if (above)
                        begin
                            motion_start_next = m_start;
                            res_mov_el        = (m_start != '0) ? m_elapsed : '0;
                        end
                        else
                        begin
                            motion_start_next = '0;
                        end
                    end
                    else
                    begin
                        motion_start_next = '0;
                        if (below && s_done)
                        begin
                            moving_next      = 1'b0;
                            still_start_next = '0;
                            res_trans        = 1'b1;
                        end
                        else if (below)
                        begin
                            still_start_next = s_start;
                            res_still_el     = (s_start != '0) ? s_elapsed : '0;
                        end
                        else
                        begin
                            still_start_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                moving_next = moving_reg;
            end
        endcase
        out_data_next = OUT_DATA_W'({res_still_el, res_mov_el, res_trans, res_supp,
                                     res_init, moving_next});
        out_valid_next = advance ? (item_valid && (item.cmd == CMD_FRAME)) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg         <= 1'b0;
            have_prev_reg      <= 1'b0;
            motion_start_reg   <= '0;
            still_start_reg    <= '0;
            suppress_until_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                moving_reg         <= moving_next;
                have_prev_reg      <= have_prev_next;
                motion_start_reg   <= motion_start_next;
                still_start_reg    <= still_start_next;
                suppress_until_reg <= suppress_until_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data              = out_data_reg;
    assign status.moving_flag    = moving_reg;
    assign status.motion_pending = (motion_start_reg != '0);
    assign status.still_pending  = (still_start_reg != '0);

endmodule

// ----- rtl/motion_hysteresis_dwell_detector_core.sv -----
// Top level of the motion hysteresis dwell detector.
`timescale 1ns / 1ps

// The detector takes one item per clock cycle when not stalled. A frame result
// passes the input stage and then the result register: the transfer loads the
// input stage, which saturates the pixel counts and forms the two threshold
// products, and the decision stage then updates the hysteresis state and loads
// the result register. Suppress and clear commands update the state in the same
// order but return no result. The input side stalls only while the result
// register and the input stage are both full and the result is not taken.
module motion_hysteresis_dwell_detector_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mhdd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [mhdd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // now_time, suppress_duration, has_frame, size_changed, changed count,
    // valid count
    input  logic [mhdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [mhdd_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // moving, initialized, suppressed, transition, moving_candidate_elapsed,
    // still_candidate_elapsed, zero fill
    output logic [mhdd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mhdd_pkg::*;

    cfg_t        cfg;
    stage_item_t item;
    logic        item_valid;
    logic        advance;
    status_t     status;

    mhdd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mhdd_ratio_stage u_ratio_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_cmd     (s_axis_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mhdd_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .status     (status)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("Input stalled while the result side was free.");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.motion_pending |-> !status.moving_flag)
        else $error("Motion candidate running while already moving.");

    assert property (@(posedge clk) disable iff (!rst_n)
        status.still_pending |-> status.moving_flag)
        else $error("Stillness candidate running while already still.");
`endif

endmodule
